// ----- sv/bmh_pkg.sv -----
// bmh_pkg: field widths and operation codes for the binary max-heap block
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package bmh_pkg;

   // fixed transaction field widths
   localparam int MODE_W  = 2;
   localparam int KEY_W   = 16;
   localparam int COUNT_W = 11;

   // operation codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

endpackage : bmh_pkg

`default_nettype wire

// ----- sv/bmh_if.sv -----
// bmh_req_if / bmh_rsp_if: valid/ready channels of the binary max-heap block
// depends on bmh_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bmh_req_if;
   logic                        valid;
   logic                        ready;
   logic [bmh_pkg::MODE_W-1:0]  mode;
   logic [bmh_pkg::KEY_W-1:0]   new_key;

   modport source (output valid, output mode, output new_key, input ready);
   modport sink   (input valid, input mode, input new_key, output ready);
endinterface : bmh_req_if

interface bmh_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bmh_pkg::KEY_W-1:0]   removed_key;
   logic                        removed_valid;
   logic [bmh_pkg::KEY_W-1:0]   top_key;
   logic [bmh_pkg::COUNT_W-1:0] entry_count;
   logic                        rejected;

   modport source (output valid, output removed_key, output removed_valid,
                   output top_key, output entry_count, output rejected, input ready);
   modport sink   (input valid, input removed_key, input removed_valid,
                   input top_key, input entry_count, input rejected, output ready);
endinterface : bmh_rsp_if

`default_nettype wire

// ----- sv/binary_max_heap_top.sv -----
// binary max-heap priority queue with a one-write one-read key memory
// depends on bmh_pkg and the channel interfaces in bmh_if.sv
// steps per request: clear, no-op, rejected insert and a delete that empties the heap
//   go straight to the response; insert reads and compares the parent for each level
//   climbed; delete moves the last entry into the root, then for each level descended
//   reads the left child, the right child if present, and compares
// one transaction at a time; reset clears the fill count, key memory left unset
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_top #(
   parameter int HEAP_DEPTH = 1024,
   parameter int KEY_BITS   = 16
) (
   input  wire        clock,
   input  wire        reset,
   bmh_req_if.sink    req_ch,
   bmh_rsp_if.source  rsp_ch
);

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1; // entry index
   localparam int CW = $clog2(HEAP_DEPTH + 1);                     // fill count
   localparam int XW = AW + 2;                                     // child index

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   // sequencer registers
   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         pos_ff, pos_in;       // hole position of the moving key
   logic [KEY_BITS-1:0]   val_ff, val_in;       // key being sifted
   logic [KEY_BITS-1:0]   lkey_ff, lkey_in;     // left child key while right is read
   logic                  right_ff, right_in;   // right child exists at this level
   logic [KEY_BITS-1:0]   top_ff, top_in;       // copy of the root entry
   logic [KEY_BITS-1:0]   removed_key_ff, removed_key_in;
   logic                  removed_valid_ff, removed_valid_in;
   logic                  rejected_ff, rejected_in;

   // key memory ports
   logic [KEY_BITS-1:0]   heap_mem [HEAP_DEPTH];
   logic [KEY_BITS-1:0]   rd_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [KEY_BITS-1:0]   mem_wd;
   logic [AW-1:0]         mem_ra;

   // address arithmetic around the hole
   logic [AW-1:0]         pos_m1;
   logic [AW-1:0]         parent_idx;
   logic [XW-1:0]         left_x;
   logic [XW-1:0]         right_x;
   logic [XW-1:0]         cnt_x;
   logic                  left_ok;
   logic                  right_ok;

   // sift-down candidate
   logic [KEY_BITS-1:0]   cand_key;
   logic [AW-1:0]         cand_idx;

   // field width adaption between the fixed transaction widths and KEY_BITS
   logic [KEY_BITS+bmh_pkg::KEY_W-1:0] key_in_wide;
   logic [KEY_BITS-1:0]                req_key;
   logic [KEY_BITS+bmh_pkg::KEY_W-1:0] removed_wide;
   logic [KEY_BITS+bmh_pkg::KEY_W-1:0] top_wide;
   logic [CW+bmh_pkg::COUNT_W-1:0]     cnt_wide;
   logic [KEY_BITS-1:0]                top_shown;

   logic req_fire;
   logic rsp_fire;

   assign key_in_wide = {{KEY_BITS{1'b0}}, req_ch.new_key};
   assign req_key     = key_in_wide[KEY_BITS-1:0];

   assign pos_m1     = pos_ff - 1'b1;
   assign parent_idx = pos_m1 >> 1;
   assign left_x     = {{(XW-AW-1){1'b0}}, pos_ff, 1'b1};
   assign right_x    = left_x + 1'b1;
   assign cnt_x      = {{(XW-CW){1'b0}}, cnt_ff};
   assign left_ok    = left_x < cnt_x;
   assign right_ok   = right_x < cnt_x;

   // pick the left child only when strictly larger than the right
   always_comb begin
      if (right_ff) begin
         if (lkey_ff > rd_ff) begin
            cand_key = lkey_ff;
            cand_idx = left_x[AW-1:0];
         end else begin
            cand_key = rd_ff;
            cand_idx = right_x[AW-1:0];
         end
      end else begin
         cand_key = rd_ff;
         cand_idx = left_x[AW-1:0];
      end
   end

   // handshakes
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == ST_RESP);
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;

   // response fields, top reads as zero on an empty heap
   assign top_shown    = (cnt_ff != '0) ? top_ff : '0;
   assign removed_wide = {{bmh_pkg::KEY_W{1'b0}}, removed_key_ff};
   assign top_wide     = {{bmh_pkg::KEY_W{1'b0}}, top_shown};
   assign cnt_wide     = {{bmh_pkg::COUNT_W{1'b0}}, cnt_ff};

   assign rsp_ch.removed_key   = removed_wide[bmh_pkg::KEY_W-1:0];
   assign rsp_ch.removed_valid = removed_valid_ff;
   assign rsp_ch.top_key       = top_wide[bmh_pkg::KEY_W-1:0];
   assign rsp_ch.entry_count   = cnt_wide[bmh_pkg::COUNT_W-1:0];
   assign rsp_ch.rejected      = rejected_ff;

   // sequencer: next state, memory control and next register values
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      pos_in           = pos_ff;
      val_in           = val_ff;
      lkey_in          = lkey_ff;
      right_in         = right_ff;
      removed_key_in   = removed_key_ff;
      removed_valid_in = removed_valid_ff;
      rejected_in      = rejected_ff;
      mem_we           = 1'b0;
      mem_wa           = pos_ff;
      mem_wd           = val_ff;
      mem_ra           = parent_idx;

      case (state_ff)
         ST_IDLE: begin
            mem_ra = pos_m1;
            if (req_fire) begin
               removed_key_in   = '0;
               removed_valid_in = 1'b0;
               rejected_in      = 1'b0;
               state_in         = ST_RESP;
               case (req_ch.mode)
                  bmh_pkg::MODE_INSERT: begin
                     if (cnt_ff >= CW'(HEAP_DEPTH)) begin
                        rejected_in = 1'b1;
                     end else begin
                        // new key starts in the hole at the end of the heap
                        pos_in   = cnt_ff[AW-1:0];
                        val_in   = req_key;
                        cnt_in   = cnt_ff + 1'b1;
                        state_in = ST_UP_RD;
                     end
                  end
                  bmh_pkg::MODE_DELETE: begin
                     if (cnt_ff != '0) begin
                        removed_key_in   = top_ff;
                        removed_valid_in = 1'b1;
                        cnt_in           = cnt_ff - 1'b1;
                        // fetch the last entry, it refills the root
                        mem_ra = cnt_in[AW-1:0];
                        if (cnt_ff != CW'(1)) begin
                           state_in = ST_DN_LOAD;
                        end
                     end
                  end
                  bmh_pkg::MODE_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                     // unused mode code: report only
                  end
               endcase
            end
         end

         ST_UP_RD: begin
            if (pos_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_RESP;
            end else begin
               mem_ra   = parent_idx;
               state_in = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (rd_ff < val_ff) begin
               // parent moves down into the hole
               mem_wd   = rd_ff;
               pos_in   = parent_idx;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_DN_LOAD: begin
            val_in   = rd_ff;
            pos_in   = '0;
            state_in = ST_DN_RDL;
         end

         ST_DN_RDL: begin
            mem_ra = left_x[AW-1:0];
            if (!left_ok) begin
               mem_we   = 1'b1;
               state_in = ST_RESP;
            end else begin
               right_in = right_ok;
               state_in = right_ok ? ST_DN_RDR : ST_DN_CMP;
            end
         end

         ST_DN_RDR: begin
            mem_ra   = right_x[AW-1:0];
            lkey_in  = rd_ff;
            state_in = ST_DN_CMP;
         end

         ST_DN_CMP: begin
            mem_we = 1'b1;
            if (cand_key > val_ff) begin
               // larger child moves up into the hole
               mem_wd   = cand_key;
               pos_in   = cand_idx;
               state_in = ST_DN_RDL;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // keep the root copy in step with every write to entry zero
      top_in = (mem_we && (mem_wa == '0)) ? mem_wd : top_ff;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      pos_ff           <= pos_in;
      val_ff           <= val_in;
      lkey_ff          <= lkey_in;
      right_ff         <= right_in;
      top_ff           <= top_in;
      removed_key_ff   <= removed_key_in;
      removed_valid_ff <= removed_valid_in;
      rejected_ff      <= rejected_in;
   end

   // key memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= heap_mem[mem_ra];
   end

endmodule : binary_max_heap_top

`default_nettype wire
